// ----- sv/lwsum_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lwsum_pkg;

  // fixed field widths of the channels
  localparam int unsigned IN_ELEM_W = 16;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned LIMIT_W   = 32;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SHRINK
  } lwsum_state_t;

endpackage : lwsum_pkg

`default_nettype wire

// ----- sv/longest_window_sum_within_limit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Longest window with sum within a limit, over a stream of non-negative elements.
//
// Channels: in_* is a valid/ready input of one element plus a last flag; out_*
// is a valid/ready result channel carrying the best length so far, the current
// window length, a sticky depth-overflow flag and an echo of the last flag.
// One result transaction is produced for every input transaction, in order.
// cfg_wr_en/cfg_wr_data write the sum limit; write it only while the block is idle.
//
// Flow: an item is accepted in ST_IDLE, then ST_SHRINK drops the oldest
// element while the sum is over the limit. The window ring buffer has one
// read port, so at most one element leaves per cycle. Every element leaves
// at most once. A new item is not taken until the last one has left
// ST_SHRINK. The result sits in an output register; a new transaction is
// taken while it waits. If the receiver stalls, the next item finishes its
// shrinking and then holds until the output register is free.
//
// Reset clears the window, the best length, the overflow flag and the limit.
// After a result marked final, the window, best length and overflow flag return to reset.

module longest_window_sum_within_limit #(
  parameter int unsigned WINDOW_DEPTH = 1024,
  parameter int unsigned ELEM_BITS    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            cfg_wr_en,
  input  wire logic [lwsum_pkg::LIMIT_W-1:0]   cfg_wr_data,

  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lwsum_pkg::IN_ELEM_W-1:0] in_elem_value,
  input  wire logic                            in_last_item,

  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lwsum_pkg::LEN_W-1:0]          out_best_length,
  output logic [lwsum_pkg::LEN_W-1:0]          out_window_length,
  output logic                                 out_depth_overflow,
  output logic                                 out_final_result
);

  import lwsum_pkg::*;

  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  // window sum is sized for WINDOW_DEPTH elements of ELEM_BITS each
  localparam int unsigned SUM_W = ELEM_BITS + CNT_W;
  localparam int unsigned CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  lwsum_state_t           state_r, state_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       best_r, best_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   last_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]       out_best_r, out_win_r;
  logic                   out_ovf_r, out_last_r;

  // ring buffer with one write and one registered read port
  logic [ELEM_BITS-1:0]   mem [WINDOW_DEPTH];
  logic [ELEM_BITS-1:0]   mem_rd_q;
  logic [ELEM_BITS-1:0]   fwd_data_r;
  logic                   fwd_sel_r;
  logic                   mem_we;
  logic [PTR_W-1:0]       rd_addr;
  logic [ELEM_BITS-1:0]   tail_val;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  logic [ELEM_BITS-1:0]   elem_w;
  logic                   accept;
  logic                   full;
  logic                   over_limit;
  logic                   shrink_go;
  logic                   done;
  logic [LEN_W-1:0]       best_len;
  logic [LEN_W-1:0]       win_len;

  // only the low bits the buffer can hold are used
  always_comb begin
    for (int i = 0; i < ELEM_BITS; i++) begin
      elem_w[i] = (i < IN_ELEM_W) ? in_elem_value[i] : 1'b0;
    end
  end

  // lengths wrap to the 11-bit result field
  always_comb begin
    for (int i = 0; i < LEN_W; i++) begin
      best_len[i] = (i < CNT_W) ? best_nxt[i] : 1'b0;
      win_len[i]  = (i < CNT_W) ? cnt_r[i]    : 1'b0;
    end
  end

  assign accept     = in_valid && in_ready;
  assign full       = (cnt_r == CNT_W'(WINDOW_DEPTH));
  assign over_limit = (CMP_W'(sum_r) > CMP_W'(limit_r));
  assign shrink_go  = (state_r == ST_SHRINK) && over_limit && (cnt_r != '0);
  // finished shrinking and the output register can take the result
  assign done       = (state_r == ST_SHRINK) && !shrink_go &&
                      (!out_valid_r || out_ready);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_valid;
      end
      ST_SHRINK: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // window datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (accept) begin
      head_nxt = ptr_inc(head_r);
      if (full) begin
        // buffer full: oldest leaves as the new element enters
        sum_nxt  = sum_r + SUM_W'(elem_w) - SUM_W'(tail_val);
        tail_nxt = ptr_inc(tail_r);
        ovf_nxt  = 1'b1;
      end else begin
        sum_nxt  = sum_r + SUM_W'(elem_w);
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end else if (shrink_go) begin
      sum_nxt  = sum_r - SUM_W'(tail_val);
      tail_nxt = ptr_inc(tail_r);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end

    if (state_r == ST_SHRINK && !shrink_go) begin
      best_nxt = (cnt_r > best_r) ? cnt_r : best_r;
    end

    if (done) begin
      out_valid_nxt = 1'b1;
    end
  end

  // read tracks the next tail so tail_val is always the oldest element
  assign rd_addr  = tail_nxt;
  assign tail_val = fwd_sel_r ? fwd_data_r : mem_rd_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_r] <= elem_w;
    end
    mem_rd_q <= mem[rd_addr];
  end

  // write/read on the same entry: forward the written element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else begin
      fwd_sel_r <= mem_we && (head_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= elem_w;
  end

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (done && last_r) begin
        // end of sequence: back to an empty window
        head_r <= '0;
        tail_r <= '0;
        cnt_r  <= '0;
        sum_r  <= '0;
        best_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
        sum_r  <= sum_nxt;
        best_r <= best_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last_item;
    end
    if (done) begin
      out_best_r <= best_len;
      out_win_r  <= win_len;
      out_ovf_r  <= ovf_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_best_length    = out_best_r;
  assign out_window_length  = out_win_r;
  assign out_depth_overflow = out_ovf_r;
  assign out_final_result   = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count above buffer depth");

  a_shrink_step: assert property (@(posedge clk) disable iff (!rst_n)
    shrink_go |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("shrink step did not remove one element");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r != '0 || sum_r == '0))
    else $error("empty window with non-zero sum");

  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (done && last_r) |=> (cnt_r == '0 && sum_r == '0 && best_r == '0 && !ovf_r))
    else $error("state not cleared after final transaction");

endmodule : longest_window_sum_within_limit

`default_nettype wire
